[rtl/assert_macros.svh]
// Assertion helpers for the blitter checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every clock edge outside reset.
`define BLT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("blitter check failed");

// Check at every clock edge, reset included.
`define BLT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("blitter check failed");

`endif

[rtl/blt_pkg.sv]
package blt_pkg;

  localparam int unsigned MaxSpriteWidth  = 1024;
  localparam int unsigned MaxCanvasDim    = 4096;
  localparam int unsigned InDepthDefault  = 4;
  localparam int unsigned OutDepthDefault = 2;

  localparam int unsigned OpW     = 1;
  localparam int unsigned CoordW  = 13;
  localparam int unsigned LenW    = 11;
  localparam int unsigned CanvasW = 13;
  localparam int unsigned StrideW = 15;
  localparam int unsigned RowW    = 17;
  localparam int unsigned RunW    = 16;
  localparam int unsigned AddrW   = 26;
  localparam int unsigned PixW    = 32;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgCanvasWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCanvasHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRowStride    = 2'd2;

  localparam logic [CanvasW-1:0] CanvasWidthReset  = 13'd640;
  localparam logic [CanvasW-1:0] CanvasHeightReset = 13'd480;
  localparam logic [StrideW-1:0] RowStrideReset    = 15'd2560;

  localparam logic [OpW-1:0] OpBegin  = 1'b0;
  localparam logic [OpW-1:0] OpStream = 1'b1;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [PixW-1:0]   data_word;
    logic              last_word;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [LenW-1:0]   sprite_width;
    logic [LenW-1:0]   clip_width;
    logic [LenW-1:0]   clip_height;
    logic              font_mode;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  pixel;
  } result_t;

  typedef struct packed {
    logic [CanvasW-1:0] canvas_width;
    logic [CanvasW-1:0] canvas_height;
    logic [StrideW-1:0] row_stride;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [RowW-1:0] dividend;
    logic [LenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [RowW-1:0] quot;
    logic [LenW-1:0] rem;
  } div_rsp_t;

  typedef enum logic {
    BackIdle,
    BackDivide
  } back_state_e;

endpackage

[rtl/blt_fifo.sv]
module blt_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/blt_div.sv]
module blt_div import blt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(RowW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RowW-1:0] quot_q, quot_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [LenW-1:0] div_q, div_d;
  logic [LenW:0]   trial;
  logic            fits;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem_q, quot_q[RowW-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(RowW - 1);
      quot_d = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = fits ? LenW'(trial - {1'b0, div_q}) : trial[LenW-1:0];
      quot_d = {quot_q[RowW-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/blt_back.sv]
module blt_back import blt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  item_t    item_i,
  input  logic     item_empty_i,
  output logic     item_pop_o,
  input  logic     res_full_i,
  output logic     res_push_o,
  output result_t  res_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i
);

  localparam logic [RowW-1:0] RowMax = '1;

  function automatic logic [PixW-1:0] shade(input logic [PixW-1:0] key,
                                            input logic [PixW-1:0] font);
    logic [PixW-1:0]    res;
    logic [2*ChanW-1:0] prod;
    res = font;
    for (int c = 0; c < 3; c++) begin
      prod = (2*ChanW)'(key[c*ChanW +: ChanW]) * (2*ChanW)'(font[c*ChanW +: ChanW]);
      res[c*ChanW +: ChanW] = prod[2*ChanW-1:ChanW];
    end
    return res;
  endfunction

  function automatic logic [StrideW-1:0] clamp_dim(input logic [CanvasW-1:0] v);
    if (32'(v) > MaxCanvasDim) begin
      return StrideW'(MaxCanvasDim);
    end
    return StrideW'(v);
  endfunction

  back_state_e       state_q, state_d;
  logic [CoordW-1:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [LenW-1:0]   row_length_q, row_length_d;
  logic [LenW-1:0]   clip_columns_q, clip_columns_d, clip_rows_q, clip_rows_d;
  logic              tint_mode_q, tint_mode_d;
  logic [PixW-1:0]   font_colour_q, font_colour_d;
  logic [LenW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [RunW-1:0]   run_left_q, run_left_d;
  logic              stopped_q, stopped_d;

  logic [LenW-1:0]   begin_len;
  logic [CoordW:0]   tx;
  logic [RowW+1:0]   ty;
  logic [StrideW-1:0] cw, ch;
  logic              pix_stop, pix_draw;
  logic [27:0]       row_bytes;
  logic [27:0]       addr_full;
  logic [RowW:0]     row_sum;
  logic [LenW-1:0]   col_next;

  always_comb begin
    begin_len = item_i.sprite_width;
    if (begin_len == '0) begin
      begin_len = LenW'(1);
    end
    if (32'(begin_len) > MaxSpriteWidth) begin
      begin_len = LenW'(MaxSpriteWidth);
    end
  end

  // Canvas position of the current sprite pixel, sign kept in the top bit.
  assign tx = {origin_x_q[CoordW-1], origin_x_q} + {3'b000, col_q};
  assign ty = {{(RowW+2-CoordW){origin_y_q[CoordW-1]}}, origin_y_q} + {2'b00, row_q};
  assign cw = clamp_dim(cfg_i.canvas_width);
  assign ch = clamp_dim(cfg_i.canvas_height);

  assign pix_stop = (!ty[RowW+1] && (ty[RowW:0] >= (RowW+1)'(ch)))
                 || (row_q >= RowW'(clip_rows_q));
  assign pix_draw = !ty[RowW+1] && !tx[CoordW]
                 && ({2'b00, tx[CoordW-1:0]} < cw)
                 && (col_q < clip_columns_q);

  assign row_bytes = 28'(ty[CanvasW-1:0]) * 28'(cfg_i.row_stride);
  assign addr_full = row_bytes + 28'({tx[CoordW-1:0], 2'b00});

  assign res_o.addr  = addr_full[AddrW-1:0];
  assign res_o.pixel = tint_mode_q ? shade(item_i.data_word, font_colour_q)
                                   : item_i.data_word;

  assign row_sum  = {1'b0, row_q} + {1'b0, div_rsp_i.quot};
  assign col_next = col_q + 1'b1;

  always_comb begin
    state_d        = state_q;
    origin_x_d     = origin_x_q;
    origin_y_d     = origin_y_q;
    row_length_d   = row_length_q;
    clip_columns_d = clip_columns_q;
    clip_rows_d    = clip_rows_q;
    tint_mode_d    = tint_mode_q;
    font_colour_d  = font_colour_q;
    col_d          = col_q;
    row_d          = row_q;
    run_left_d     = run_left_q;
    stopped_d      = stopped_q;
    item_pop_o     = 1'b0;
    res_push_o     = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = RowW'(col_q) + RowW'(item_i.data_word[RunW-1:0]);
    div_req_o.divisor  = row_length_q;

    unique case (state_q)
      BackIdle: begin
        if (!item_empty_i) begin
          if (item_i.op == OpBegin) begin
            item_pop_o     = 1'b1;
            origin_x_d     = item_i.pos_x;
            origin_y_d     = item_i.pos_y;
            row_length_d   = begin_len;
            clip_columns_d = item_i.clip_width;
            clip_rows_d    = item_i.clip_height;
            tint_mode_d    = item_i.font_mode;
            font_colour_d  = item_i.data_word;
            col_d          = '0;
            row_d          = '0;
            run_left_d     = '0;
            stopped_d      = 1'b0;
          end else if (stopped_q) begin
            // drop stream words until the next begin
            item_pop_o = 1'b1;
          end else if (run_left_q == '0) begin
            // header: fold the skip into column and row
            item_pop_o      = 1'b1;
            div_req_o.start = 1'b1;
            run_left_d      = item_i.data_word[PixW-1:RunW];
            stopped_d       = item_i.last_word;
            state_d         = BackDivide;
          end else if (!res_full_i) begin
            item_pop_o = 1'b1;
            if (pix_stop) begin
              stopped_d = 1'b1;
            end else begin
              res_push_o = pix_draw;
              run_left_d = run_left_q - 1'b1;
              if (col_next == row_length_q) begin
                col_d = '0;
                row_d = (row_q == RowMax) ? RowMax : row_q + 1'b1;
              end else begin
                col_d = col_next;
              end
            end
            if (item_i.last_word) begin
              stopped_d = 1'b1;
            end
          end
        end
      end
      BackDivide: begin
        if (div_rsp_i.done) begin
          col_d   = div_rsp_i.rem;
          row_d   = row_sum[RowW] ? RowMax : row_sum[RowW-1:0];
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BackIdle;
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      row_length_q   <= LenW'(1);
      clip_columns_q <= LenW'(1);
      clip_rows_q    <= LenW'(1);
      tint_mode_q    <= 1'b0;
      font_colour_q  <= '0;
      col_q          <= '0;
      row_q          <= '0;
      run_left_q     <= '0;
      stopped_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      origin_x_q     <= origin_x_d;
      origin_y_q     <= origin_y_d;
      row_length_q   <= row_length_d;
      clip_columns_q <= clip_columns_d;
      clip_rows_q    <= clip_rows_d;
      tint_mode_q    <= tint_mode_d;
      font_colour_q  <= font_colour_d;
      col_q          <= col_d;
      row_q          <= row_d;
      run_left_q     <= run_left_d;
      stopped_q      <= stopped_d;
    end
  end

endmodule

[rtl/rle_sprite_clipped_blitter.sv]
// Channel   Direction  Handshake           Payload
// input     in         push / full         op, data_word, last_word, pos_x/y, sizes, font_mode
// result    out        empty / pop         write_address, pixel_value
// config    in         cfg_we_i            cfg_index_i, cfg_data_i
//
// Begin items and pixel words are taken straight from the idle state; a header word
// waits in BackDivide for the bit-serial divider that splits the skip into column and row.
// A drawn pixel reaches the result queue in the cycle after acceptance at the earliest.
// Reset empties both queues, rewinds the sprite state and loads 640 x 480, stride 2560.
// full rises when the input queue holds InDepth items; a pixel word waits in the
// input queue until the result queue has room.
module rle_sprite_clipped_blitter import blt_pkg::*; #(
  parameter int unsigned InDepth  = InDepthDefault,
  parameter int unsigned OutDepth = OutDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [OpW-1:0]     op_i,
  input  logic [PixW-1:0]    data_word_i,
  input  logic               last_word_i,
  input  logic [CoordW-1:0]  pos_x_i,
  input  logic [CoordW-1:0]  pos_y_i,
  input  logic [LenW-1:0]    sprite_width_i,
  input  logic [LenW-1:0]    clip_width_i,
  input  logic [LenW-1:0]    clip_height_i,
  input  logic               font_mode_i,
  output logic               empty,
  input  logic               pop,
  output logic [AddrW-1:0]   write_address_o,
  output logic [PixW-1:0]    pixel_value_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [StrideW-1:0] cfg_data_i
);

  localparam int unsigned ItemW = $bits(item_t);
  localparam int unsigned ResW  = $bits(result_t);

  cfg_t     cfg_q;
  item_t    in_item, q_item;
  logic     q_empty, q_pop;
  result_t  back_res, out_res;
  logic     res_full, res_push;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.canvas_width  <= CanvasWidthReset;
      cfg_q.canvas_height <= CanvasHeightReset;
      cfg_q.row_stride    <= RowStrideReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCanvasWidth:  cfg_q.canvas_width  <= cfg_data_i[CanvasW-1:0];
        CfgCanvasHeight: cfg_q.canvas_height <= cfg_data_i[CanvasW-1:0];
        CfgRowStride:    cfg_q.row_stride    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.op           = op_i;
  assign in_item.data_word    = data_word_i;
  assign in_item.last_word    = last_word_i;
  assign in_item.pos_x        = pos_x_i;
  assign in_item.pos_y        = pos_y_i;
  assign in_item.sprite_width = sprite_width_i;
  assign in_item.clip_width   = clip_width_i;
  assign in_item.clip_height  = clip_height_i;
  assign in_item.font_mode    = font_mode_i;

  blt_fifo #(
    .Width(ItemW),
    .Depth(InDepth)
  ) u_in_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .data_i (in_item),
    .full_o (full),
    .pop_i  (q_pop),
    .data_o (q_item),
    .empty_o(q_empty)
  );

  blt_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .item_i      (q_item),
    .item_empty_i(q_empty),
    .item_pop_o  (q_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  blt_div u_div (
    .clk_i,
    .rst_ni,
    .req_i(div_req),
    .rsp_o(div_rsp)
  );

  blt_fifo #(
    .Width(ResW),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i (res_push),
    .data_i (back_res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_res),
    .empty_o(empty)
  );

  assign write_address_o = out_res.addr;
  assign pixel_value_o   = out_res.pixel;

endmodule

[rtl/blt_checker.sv]
`include "assert_macros.svh"

module blt_checker import blt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [AddrW-1:0] write_address_o,
  input logic [PixW-1:0]  pixel_value_o
);

  // Queues come out of reset with no item and with room.
  `BLT_ASSERT_ALWAYS(a_reset_clears, !rst_ni |-> empty && !full)
  // No result can reach the output in the first cycle after reset.
  `BLT_ASSERT_ALWAYS(a_reset_settles, $past(!rst_ni) |-> empty)
  `BLT_ASSERT(a_result_stays, !empty && !pop |=> !empty)
  `BLT_ASSERT(a_payload_holds,
    !empty && !pop |=> $stable(write_address_o) && $stable(pixel_value_o))

endmodule

bind rle_sprite_clipped_blitter blt_checker u_blt_checker (.*);

[tb/rle_sprite_clipped_blitter_tb.sv]
`timescale 1ns / 1ps

module rle_sprite_clipped_blitter_tb;
  import blt_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int QuietCycles   = (InDepthDefault + OutDepthDefault) * 25;
  localparam int StallCycles   = 400;
  localparam int TimeoutCycles = 600000;
  localparam int ReportLimit   = 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [OpW-1:0]     op_i = '0;
  logic [PixW-1:0]    data_word_i = '0;
  logic               last_word_i = 1'b0;
  logic [CoordW-1:0]  pos_x_i = '0;
  logic [CoordW-1:0]  pos_y_i = '0;
  logic [LenW-1:0]    sprite_width_i = '0;
  logic [LenW-1:0]    clip_width_i = '0;
  logic [LenW-1:0]    clip_height_i = '0;
  logic               font_mode_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [AddrW-1:0]   write_address_o;
  logic [PixW-1:0]    pixel_value_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [StrideW-1:0] cfg_data_i = '0;

  rle_sprite_clipped_blitter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .data_word_i    (data_word_i),
    .last_word_i    (last_word_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .sprite_width_i (sprite_width_i),
    .clip_width_i   (clip_width_i),
    .clip_height_i  (clip_height_i),
    .font_mode_i    (font_mode_i),
    .empty          (empty),
    .pop            (pop),
    .write_address_o(write_address_o),
    .pixel_value_o  (pixel_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Canvas registers as the blitter should hold them
  logic [CanvasW-1:0] cv_width  = CanvasWidthReset;
  logic [CanvasW-1:0] cv_height = CanvasHeightReset;
  logic [StrideW-1:0] cv_stride = RowStrideReset;

  // Sprite walk state
  logic signed [CoordW-1:0] org_x = '0;
  logic signed [CoordW-1:0] org_y = '0;
  logic [LenW-1:0]  row_len     = 11'd1;
  logic [LenW-1:0]  clip_cols   = 11'd1;
  logic [LenW-1:0]  clip_rows_n = 11'd1;
  logic             tint_on     = 1'b0;
  logic [PixW-1:0]  font_col    = '0;
  logic [9:0]       spr_col     = '0;
  logic [RowW-1:0]  spr_row     = '0;
  logic [RunW-1:0]  run_left    = '0;
  logic             halted      = 1'b0;

  item_t   stim_q[$];
  result_t expected_writes[$];
  item_t   offered;
  int      error_count = 0;
  int      idle_pct = 34;
  logic    stall_go = 1'b0;
  int      stall_left = 0;

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= ReportLimit) $display("%s", msg);
  endtask

  function automatic void step_position(input int unsigned n);
    int unsigned col, row;
    col = 32'(spr_col) + n;
    row = 32'(spr_row) + col / 32'(row_len);
    spr_col = 10'(col % 32'(row_len));
    spr_row = (row > 32'h1_FFFF) ? 17'h1_FFFF : row[RowW-1:0];
  endfunction

  function automatic logic [PixW-1:0] tint(input logic [PixW-1:0] key);
    logic [PixW-1:0]    res;
    logic [2*ChanW-1:0] prod;
    res = {font_col[PixW-1:3*ChanW], 24'h0};
    for (int c = 0; c < 3; c++) begin
      prod = (2*ChanW)'(key[c*ChanW +: ChanW]) * (2*ChanW)'(font_col[c*ChanW +: ChanW]);
      res[c*ChanW +: ChanW] = prod[2*ChanW-1:ChanW];
    end
    return res;
  endfunction

  function automatic void blit_predict(input item_t it);
    int unsigned w, addr;
    int          tx, ty, cw, ch;
    result_t     r;
    if (it.op == OpBegin) begin
      w = 32'(it.sprite_width);
      if (w == 0) w = 1;
      if (w > MaxSpriteWidth) w = MaxSpriteWidth;
      org_x       = it.pos_x;
      org_y       = it.pos_y;
      row_len     = w[LenW-1:0];
      clip_cols   = it.clip_width;
      clip_rows_n = it.clip_height;
      tint_on     = it.font_mode;
      font_col    = it.data_word;
      spr_col     = '0;
      spr_row     = '0;
      run_left    = '0;
      halted      = 1'b0;
      return;
    end
    if (halted) return;
    if (run_left == 0) begin
      step_position(32'(it.data_word[RunW-1:0]));
      run_left = it.data_word[PixW-1:RunW];
    end else begin
      tx = int'(org_x) + int'(spr_col);
      ty = int'(org_y) + int'(spr_row);
      cw = (cv_width > MaxCanvasDim) ? MaxCanvasDim : int'(cv_width);
      ch = (cv_height > MaxCanvasDim) ? MaxCanvasDim : int'(cv_height);
      if (ty >= ch || spr_row >= clip_rows_n) begin
        halted = 1'b1;
      end else begin
        if (ty >= 0 && tx >= 0 && tx < cw && spr_col < clip_cols) begin
          addr    = int'(tx) * 4 + int'(ty) * int'(cv_stride);
          r.addr  = addr[AddrW-1:0];
          r.pixel = tint_on ? tint(it.data_word) : it.data_word;
          expected_writes.push_back(r);
        end
        step_position(1);
        run_left--;
      end
    end
    if (it.last_word) halted = 1'b1;
  endfunction

  // Driver: offer the head of the queue, retire it on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        blit_predict(offered);
        void'(stim_q.pop_front());
      end
      if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        offered = stim_q[0];
        push           <= 1'b1;
        op_i           <= offered.op;
        data_word_i    <= offered.data_word;
        last_word_i    <= offered.last_word;
        pos_x_i        <= offered.pos_x;
        pos_y_i        <= offered.pos_y;
        sprite_width_i <= offered.sprite_width;
        clip_width_i   <= offered.clip_width;
        clip_height_i  <= offered.clip_height;
        font_mode_i    <= offered.font_mode;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_go) stall_left <= StallCycles;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // Monitor: compare each popped write with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_w;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_writes.size() == 0) begin
          flag_error($sformatf("unexpected write: address %h pixel %h",
                               write_address_o, pixel_value_o));
        end else begin
          exp_w = expected_writes.pop_front();
          if (write_address_o !== exp_w.addr)
            flag_error($sformatf("write_address mismatch: expected %h, got %h",
                                 exp_w.addr, write_address_o));
          if (pixel_value_o !== exp_w.pixel)
            flag_error($sformatf("pixel_value mismatch: expected %h, got %h",
                                 exp_w.pixel, pixel_value_o));
        end
      end
      pop <= (stall_left == 0) && ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t stream_word(input logic [PixW-1:0] data, input logic last);
    item_t it;
    it           = noise_item();
    it.op        = OpStream;
    it.data_word = data;
    it.last_word = last;
    return it;
  endfunction

  function automatic item_t begin_item(input int x, input int y, input int w, input int cw,
                                       input int ch, input logic fm, input logic [PixW-1:0] colour,
                                       input logic last);
    item_t it;
    it.op           = OpBegin;
    it.data_word    = colour;
    it.last_word    = last;
    it.pos_x        = x[CoordW-1:0];
    it.pos_y        = y[CoordW-1:0];
    it.sprite_width = w[LenW-1:0];
    it.clip_width   = cw[LenW-1:0];
    it.clip_height  = ch[LenW-1:0];
    it.font_mode    = fm;
    return it;
  endfunction

  // Queue whole sprites until target items; some are cut short, some trail stray words
  function automatic void fill_random(input int target);
    item_t it;
    int    n, cw, ch, w, runs, cnt, skip;
    bit    cut;
    n  = 0;
    cw = (cv_width > MaxCanvasDim) ? MaxCanvasDim : int'(cv_width);
    ch = (cv_height > MaxCanvasDim) ? MaxCanvasDim : int'(cv_height);
    while (n < target) begin
      it    = noise_item();
      it.op = OpBegin;
      if ($urandom_range(9) != 0) begin
        case ($urandom_range(14))
          0:       w = MaxSpriteWidth;
          1:       w = $urandom_range(2047);
          default: w = $urandom_range(1, 24);
        endcase
        it.sprite_width = w[LenW-1:0];
        it.pos_x        = CoordW'($urandom_range(cw + 15) - 8);
        it.pos_y        = CoordW'($urandom_range(ch + 7) - 4);
        it.clip_width   = LenW'($urandom_range(w + 2));
        it.clip_height  = LenW'($urandom_range(12));
      end
      w = 32'(it.sprite_width);
      if (w == 0) w = 1;
      if (w > MaxSpriteWidth) w = MaxSpriteWidth;
      stim_q.push_back(it);
      n++;
      cut  = ($urandom_range(9) == 0);
      runs = $urandom_range(1, 6);
      for (int r = 0; r < runs; r++) begin
        skip = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(w + 2);
        cnt  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        stim_q.push_back(stream_word({cnt[RunW-1:0], skip[RunW-1:0]}, 1'b0));
        n++;
        // drop the tail of the final run on a broken sprite
        if (cut && r == runs - 1) cnt = cnt / 2;
        for (int p = 0; p < cnt; p++) begin
          stim_q.push_back(stream_word($urandom, 1'b0));
          n++;
        end
      end
      if (!cut) stim_q[stim_q.size() - 1].last_word = 1'b1;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3))
          stim_q.push_back(stream_word($urandom, 1'($urandom_range(1))));
      end
    end
  endfunction

  task automatic settle();
    while (stim_q.size() != 0 || expected_writes.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[StrideW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgCanvasWidth:  cv_width  = val[CanvasW-1:0];
      CfgCanvasHeight: cv_height = val[CanvasW-1:0];
      CfgRowStride:    cv_stride = val[StrideW-1:0];
      default: ;
    endcase
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // stream before any begin: draws with the reset sprite state
    stim_q.push_back(stream_word(32'h0002_0000, 1'b0));
    stim_q.push_back(stream_word(32'hA1B2_C3D4, 1'b0));
    stim_q.push_back(stream_word(32'h5566_7788, 1'b0));
    // font mode, left edge off canvas, column clip, empty run, clip bottom
    stim_q.push_back(begin_item(-1, 0, 4, 3, 2, 1'b1, 32'hC0FF_8001, 1'b0));
    stim_q.push_back(stream_word(32'h0004_0000, 1'b0));
    stim_q.push_back(stream_word(32'hFFFF_FFFF, 1'b0));
    stim_q.push_back(stream_word(32'h0000_0000, 1'b0));
    stim_q.push_back(stream_word(32'h1234_5678, 1'b0));
    stim_q.push_back(stream_word(32'hFFFF_FFFF, 1'b0));
    stim_q.push_back(stream_word(32'h0000_0000, 1'b0));
    stim_q.push_back(stream_word(32'h0001_0004, 1'b0));
    stim_q.push_back(stream_word(32'hFFFF_FFFF, 1'b1));
    // copy mode at the bottom right corner, oversized width, stray word after last
    stim_q.push_back(begin_item(638, 479, 2047, 2047, 2047, 1'b0, 32'h0, 1'b1));
    stim_q.push_back(stream_word(32'h0003_0000, 1'b0));
    stim_q.push_back(stream_word(32'hFFFF_FFFF, 1'b0));
    stim_q.push_back(stream_word(32'h0000_0000, 1'b0));
    stim_q.push_back(stream_word(32'h8040_2010, 1'b1));
    stim_q.push_back(stream_word(32'h0001_0000, 1'b0));
    // zero width, zero clip, below the canvas bottom
    stim_q.push_back(begin_item(-4096, 4095, 0, 0, 0, 1'b1, 32'hFFFF_FFFF, 1'b0));
    stim_q.push_back(stream_word(32'h0001_0000, 1'b0));
    stim_q.push_back(stream_word(32'h0102_0304, 1'b0));
    // row counter saturates instead of wrapping back into the clip
    stim_q.push_back(begin_item(0, 0, 1, 1, 5, 1'b0, 32'h0, 1'b0));
    stim_q.push_back(stream_word(32'h0000_FFFF, 1'b0));
    stim_q.push_back(stream_word(32'h0000_FFFF, 1'b0));
    stim_q.push_back(stream_word(32'h0001_0002, 1'b0));
    stim_q.push_back(stream_word(32'hDEAD_BEEF, 1'b1));
    fill_random(150);
    settle();

    write_reg(CfgCanvasWidth, 1);
    write_reg(CfgCanvasHeight, 1);
    write_reg(CfgRowStride, 4);
    fill_random(60);
    settle();

    write_reg(CfgCanvasWidth, 8191);
    write_reg(CfgCanvasHeight, 4096);
    write_reg(CfgRowStride, 32767);
    fill_random(150);
    settle();

    write_reg(CfgCanvasWidth, 0);
    write_reg(CfgCanvasHeight, 0);
    write_reg(CfgRowStride, 16384);
    fill_random(40);
    settle();

    write_reg(CfgCanvasWidth, 160);
    write_reg(CfgCanvasHeight, 120);
    write_reg(CfgRowStride, 640);
    // hold the receiver while a long run of visible pixels backs up the block
    @(posedge clk_i);
    stall_go <= 1'b1;
    @(posedge clk_i);
    stall_go <= 1'b0;
    stim_q.push_back(begin_item(10, 10, 64, 64, 64, 1'b0, 32'h0, 1'b0));
    stim_q.push_back(stream_word(32'h0028_0000, 1'b0));
    for (int p = 0; p < 40; p++) stim_q.push_back(stream_word($urandom, p == 39));
    settle();
    fill_random(150);
    settle();

    write_reg(CfgCanvasWidth, 640);
    write_reg(CfgCanvasHeight, 8191);
    write_reg(CfgRowStride, 2560);
    @(posedge clk_i);
    idle_pct <= 0;
    fill_random(150);
    settle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/blt_pkg.sv
rtl/blt_fifo.sv
rtl/blt_div.sv
rtl/blt_back.sv
rtl/rle_sprite_clipped_blitter.sv
rtl/blt_checker.sv
tb/rle_sprite_clipped_blitter_tb.sv
